// ----- design/dmc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_pkg
// Shared constants, field widths and transaction types of the tag lookup.
// ----------------------------------------------------------------------------
package dmc_pkg;

    localparam int NUM_LINES   = 128;
    localparam int BLOCK_BYTES = 32;
    localparam int ADDR_BITS   = 32;

    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int IDX_W = $clog2(NUM_LINES);
    localparam int BLK_W = ADDR_BITS - OFF_W;
    localparam int TAG_W = BLK_W - IDX_W;
    localparam int CNT_W = 32;

    typedef enum logic
    {
        FUNC_READ  = 1'b0,
        FUNC_WRITE = 1'b1
    } func_t;

    typedef struct packed
    {
        logic [ADDR_BITS-1:0] address;
        func_t                func;
    } req_t;

    typedef struct packed
    {
        logic [OFF_W-1:0] byte_offset;
        logic [BLK_W-1:0] block_number;
        logic [IDX_W-1:0] line_index;
        logic [TAG_W-1:0] tag_value;
        logic             miss;
        logic             mem_read;
        logic             mem_write;
        logic             replacement;
        logic [TAG_W-1:0] evicted_tag;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
    } resp_t;

    // Tag RAM access group
    typedef struct packed
    {
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr;
        logic             wr_en;
        logic [IDX_W-1:0] wr_addr;
        logic [TAG_W-1:0] wr_data;
    } ram_req_t;

endpackage

// ----- design/dmc_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_req_if / dmc_rsp_if
// Valid/ready channels for lookup requests and results.
// ----------------------------------------------------------------------------
interface dmc_req_if import dmc_pkg::*;;
    logic valid;
    logic ready;
    req_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface dmc_rsp_if import dmc_pkg::*;;
    logic  valid;
    logic  ready;
    resp_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ----- design/dmc_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dmc_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read during write to the same entry returns the old data
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- design/dmc_lookup.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmc_lookup
// Lookup stage: tag compare, valid bits, fill write-back, forwarding, counters.
// ----------------------------------------------------------------------------
module dmc_lookup import dmc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    dmc_req_if.sink          req,
    output ram_req_t         ram_req,
    input  logic [TAG_W-1:0] ram_rdata,
    input  logic             out_free,
    output logic             result_valid,
    output resp_t            result
);

    logic                 lk_valid_reg, lk_valid_next;
    req_t                 lk_req_reg;
    logic                 fwd_valid_reg, fwd_valid_next;
    logic [TAG_W-1:0]     fwd_tag_reg;
    logic [NUM_LINES-1:0] line_valid_reg;
    logic [CNT_W-1:0]     hit_cnt_reg, hit_cnt_next;
    logic [CNT_W-1:0]     miss_cnt_reg, miss_cnt_next;

    logic             accept;
    logic             advance;
    logic [IDX_W-1:0] in_idx;
    logic [IDX_W-1:0] lk_idx;
    logic [TAG_W-1:0] lk_tag;
    logic [TAG_W-1:0] stored_tag;
    logic             line_vld;
    logic             hit;
    logic             fill;

    assign in_idx = req.data.address[OFF_W +: IDX_W];
    assign lk_idx = lk_req_reg.address[OFF_W +: IDX_W];
    assign lk_tag = lk_req_reg.address[ADDR_BITS-1 -: TAG_W];

    assign advance   = lk_valid_reg && out_free;
    assign req.ready = !lk_valid_reg || out_free;
    assign accept    = req.valid && req.ready;

    // RAM data predates a fill done on the same edge as the read
    assign stored_tag = fwd_valid_reg ? fwd_tag_reg : ram_rdata;
    assign line_vld   = line_valid_reg[lk_idx];
    assign hit        = line_vld && (stored_tag == lk_tag);
    assign fill       = !hit && (lk_req_reg.func == FUNC_READ);

    always_comb
    begin
        ram_req.rd_en   = accept;
        ram_req.rd_addr = in_idx;
        ram_req.wr_en   = advance && fill;
        ram_req.wr_addr = lk_idx;
        ram_req.wr_data = lk_tag;
    end

    always_comb
    begin
        lk_valid_next = lk_valid_reg;
        if (accept)
        begin
            lk_valid_next = 1'b1;
        end
        else if (advance)
        begin
            lk_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        fwd_valid_next = fwd_valid_reg;
        if (accept)
        begin
            fwd_valid_next = ram_req.wr_en && (ram_req.wr_addr == in_idx);
        end
        else if (advance)
        begin
            fwd_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        if (advance)
        begin
            if (hit)
            begin
                hit_cnt_next = hit_cnt_reg + CNT_W'(1);
            end
            else
            begin
                miss_cnt_next = miss_cnt_reg + CNT_W'(1);
            end
        end
    end

    always_comb
    begin
        result_valid        = advance;
        result.byte_offset  = lk_req_reg.address[OFF_W-1:0];
        result.block_number = lk_req_reg.address[ADDR_BITS-1:OFF_W];
        result.line_index   = lk_idx;
        result.tag_value    = lk_tag;
        result.miss         = !hit;
        result.mem_read     = fill;
        result.mem_write    = (lk_req_reg.func == FUNC_WRITE);
        result.replacement  = fill && line_vld;
        result.evicted_tag  = (fill && line_vld) ? stored_tag : '0;
        result.hit_total    = hit_cnt_next;
        result.miss_total   = miss_cnt_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lk_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
            line_valid_reg <= '0;
            hit_cnt_reg    <= '0;
            miss_cnt_reg   <= '0;
        end
        else
        begin
            lk_valid_reg  <= lk_valid_next;
            fwd_valid_reg <= fwd_valid_next;
            hit_cnt_reg   <= hit_cnt_next;
            miss_cnt_reg  <= miss_cnt_next;
            if (ram_req.wr_en)
            begin
                line_valid_reg[lk_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            lk_req_reg  <= req.data;
            fwd_tag_reg <= ram_req.wr_data;
        end
    end

`ifndef ASSERT_OFF
    a_fill_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ram_req.wr_en |=> line_valid_reg[$past(ram_req.wr_addr)])
        else $error("line not valid after fill");

    a_one_count_per_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> CNT_W'(hit_cnt_reg + miss_cnt_reg)
                    == CNT_W'($past(hit_cnt_reg + miss_cnt_reg) + CNT_W'(1)))
        else $error("counters out of step with results");

    a_counts_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(hit_cnt_reg) && $stable(miss_cnt_reg))
        else $error("counter moved without a result");

    a_fwd_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> lk_valid_reg)
        else $error("forwarded tag held with no lookup pending");
`endif

endmodule

// ----- design/direct_mapped_cache_tag_lookup_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// direct_mapped_cache_tag_lookup_top
// Tag controller of a 128-line, 32-byte-block direct-mapped cache,
// write-through and write-no-allocate.
// ----------------------------------------------------------------------------
// Usage:
//   req  - one transaction per memory reference: byte address and func
//          (read or write).
//   rsp  - one transaction per reference, in order: address split, miss,
//          memory read/write requests, replacement with evicted tag, and
//          the running hit and miss totals after this reference.
// Order: the tag RAM read is issued on the accept edge; the compare runs
//   in the cycle after it, and the result is registered into the output
//   register once that register is free, which raises rsp.valid.
// Throughput: one transaction per cycle while rsp.ready stays high, with
//   the one-entry lookup stage. A fill written on the same edge as
//   the following reference's RAM read is forwarded to it.
// Reset: valid bits and both counters clear at once; the tag RAM is not
//   cleared, a line is only compared once its valid bit is set.
// Stall: while rsp.ready is low the output register holds its result and
//   one more reference may wait in the lookup stage; req.ready then drops.
// ----------------------------------------------------------------------------
module direct_mapped_cache_tag_lookup_top import dmc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    dmc_req_if.sink    req,
    dmc_rsp_if.source  rsp
);

    ram_req_t         ram_req;
    logic [TAG_W-1:0] ram_rdata;
    logic             out_free;
    logic             result_valid;
    resp_t            result;

    logic  out_valid_reg, out_valid_next;
    resp_t out_data_reg;

    // Tag store, one entry per cache line
    dmc_ram
    #(
        .WIDTH (TAG_W),
        .DEPTH (NUM_LINES)
    )
    u_tag_ram
    (
        .clk   (clk),
        .we    (ram_req.wr_en),
        .waddr (ram_req.wr_addr),
        .wdata (ram_req.wr_data),
        .re    (ram_req.rd_en),
        .raddr (ram_req.rd_addr),
        .rdata (ram_rdata)
    );

    dmc_lookup u_lookup
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .req          (req),
        .ram_req      (ram_req),
        .ram_rdata    (ram_rdata),
        .out_free     (out_free),
        .result_valid (result_valid),
        .result       (result)
    );

    // Output register: takes a new result when empty or being drained
    assign out_free = !out_valid_reg || rsp.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_valid)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (result_valid)
        begin
            out_data_reg <= result;
        end
    end

    assign rsp.valid = out_valid_reg;
    assign rsp.data  = out_data_reg;

endmodule
